/* sv/fifo_wait_queue_with_removal_core_macros.svh */
// assertion macros shared by the wait queue rtl
// expects signals named clk and rst_n in the using module
`ifndef FIFO_WAIT_QUEUE_WITH_REMOVAL_CORE_MACROS_SVH
`define FIFO_WAIT_QUEUE_WITH_REMOVAL_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define FWQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define FWQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/fwq_pkg.sv */
// shared constants, codes and control structs of the wait queue
// no dependencies
package fwq_pkg;

    localparam int NUM_WAITERS  = 16;
    localparam int RESULT_LIMIT = 16;
    localparam int ID_W         = 4;
    localparam int COUNT_W      = 7;
    localparam int SLOT_W       = $clog2(NUM_WAITERS);
    localparam int LINK_W       = $clog2(NUM_WAITERS + 1);
    localparam int REM_W        = $clog2(RESULT_LIMIT + 1);
    localparam int CMP_W        = (LINK_W > ID_W) ? LINK_W : ID_W;

    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(NUM_WAITERS);

    typedef enum logic [1:0] {
        ACT_WAIT      = 2'd0,
        ACT_UNWAIT    = 2'd1,
        ACT_WAKE_MANY = 2'd2,
        ACT_WAKE_ONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_UNLINK,
        ST_WALK
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture the input word
        logic append;     // link the item at the tail
        logic rd_item;    // read both links of the item slot
        logic unlink;     // splice the item out using the read links
        logic rd_head;    // read the next link of the head slot
        logic walk;       // pop the head, emit it, prefetch the following link
        logic emit_none;  // emit a result without a woken id
        logic dup;        // flag the result as a duplicate wait
        logic emit_id;    // emit the item id without touching the list
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        action_t action;
        logic    id_ok;
        logic    item_queued;
        logic    cnt_zero;
        logic    walk_last;
    } sts_t;

endpackage

/* sv/fwq_ram.sv */
// generic single write port ram with one registered read port
// no dependencies
module fwq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/fwq_ctrl.sv */
// sequencing state machine of the wait queue
// depends on fwq_pkg
module fwq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  fwq_pkg::sts_t sts,
    output fwq_pkg::cmd_t cmd,
    output logic          busy
);
    import fwq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                case (sts.action)
                    ACT_UNWAIT, ACT_WAKE_ONE:
                    begin
                        if (sts.item_queued)
                        begin
                            state_next = ST_UNLINK;
                        end
                    end
                    ACT_WAKE_MANY:
                    begin
                        if (!sts.cnt_zero)
                        begin
                            state_next = ST_WALK;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_UNLINK:
            begin
                state_next = ST_IDLE;
            end
            ST_WALK:
            begin
                if (sts.walk_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load = start;
            end
            ST_EXEC:
            begin
                case (sts.action)
                    ACT_WAIT:
                    begin
                        cmd.emit_none = 1'b1;
                        cmd.dup       = sts.item_queued;
                        cmd.append    = sts.id_ok && !sts.item_queued;
                    end
                    ACT_UNWAIT:
                    begin
                        cmd.rd_item   = sts.item_queued;
                        cmd.emit_none = !sts.item_queued;
                    end
                    ACT_WAKE_MANY:
                    begin
                        cmd.rd_head   = !sts.cnt_zero;
                        cmd.emit_none = sts.cnt_zero;
                    end
                    ACT_WAKE_ONE:
                    begin
                        cmd.rd_item   = sts.item_queued;
                        cmd.emit_id   = sts.id_ok && !sts.item_queued;
                        cmd.emit_none = !sts.id_ok;
                    end
                    default:
                    begin
                        cmd.emit_none = 1'b1;
                    end
                endcase
            end
            ST_UNLINK:
            begin
                cmd.unlink = 1'b1;
            end
            ST_WALK:
            begin
                cmd.walk = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

/* sv/fwq_dp.sv */
// datapath of the wait queue: list registers, link rams, result register
// depends on fwq_pkg, fwq_ram and the assertion macro header
`include "fifo_wait_queue_with_removal_core_macros.svh"

module fwq_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [1:0]                 action,
    input  logic [fwq_pkg::ID_W-1:0]   waiter_id,
    input  logic [fwq_pkg::COUNT_W-1:0] wake_count,
    input  fwq_pkg::cmd_t              cmd,
    output fwq_pkg::sts_t              sts,
    output logic                       done,
    output logic                       woken_valid,
    output logic [fwq_pkg::ID_W-1:0]   woken_id,
    output logic                       last,
    output logic                       queue_empty,
    output logic                       status
);
    import fwq_pkg::*;

    // captured input word
    action_t              action_reg;
    logic [ID_W-1:0]      id_reg;
    logic [COUNT_W-1:0]   count_reg;

    // list state
    logic [LINK_W-1:0]      head_reg, head_next;
    logic [LINK_W-1:0]      tail_reg, tail_next;
    logic [LINK_W-1:0]      occ_reg, occ_next;
    logic [NUM_WAITERS-1:0] queued_reg, queued_next;
    logic [REM_W-1:0]       rem_reg, rem_next;

    // result register
    logic            done_reg, done_next;
    logic            valid_reg, valid_next;
    logic [ID_W-1:0] wid_reg, wid_next;
    logic            last_reg, last_next;
    logic            empty_reg, empty_next;
    logic            status_reg, status_next;

    // link rams
    logic              nx_we, nx_re, pv_we, pv_re;
    logic [SLOT_W-1:0] nx_waddr, nx_raddr, pv_waddr, pv_raddr;
    logic [LINK_W-1:0] nx_wdata, pv_wdata, next_rd, prev_rd;

    logic              id_ok;
    logic [SLOT_W-1:0] id_slot;
    logic [LINK_W-1:0] id_link;
    logic [LINK_W-1:0] ul_p, ul_n, wk_n;
    logic [COUNT_W-1:0] occ_ext, clamp_a;
    logic [REM_W-1:0]   clamp;

    fwq_ram #(.WIDTH(LINK_W), .DEPTH(NUM_WAITERS)) u_next_ram (
        .clk   (clk),
        .we    (nx_we),
        .waddr (nx_waddr),
        .wdata (nx_wdata),
        .re    (nx_re),
        .raddr (nx_raddr),
        .rdata (next_rd)
    );

    fwq_ram #(.WIDTH(LINK_W), .DEPTH(NUM_WAITERS)) u_prev_ram (
        .clk   (clk),
        .we    (pv_we),
        .waddr (pv_waddr),
        .wdata (pv_wdata),
        .re    (pv_re),
        .raddr (pv_raddr),
        .rdata (prev_rd)
    );

    always_comb
    begin
        id_ok   = (CMP_W'(id_reg) < CMP_W'(NUM_WAITERS));
        id_slot = SLOT_W'(id_reg);
        id_link = LINK_W'(id_reg);
        // end links are not taken from the rams, the head and tail decide them
        ul_p    = (head_reg == id_link) ? NIL_LINK : prev_rd;
        ul_n    = (tail_reg == id_link) ? NIL_LINK : next_rd;
        wk_n    = (head_reg == tail_reg) ? NIL_LINK : next_rd;
        occ_ext = COUNT_W'(occ_reg);
        clamp_a = (count_reg < occ_ext) ? count_reg : occ_ext;
        clamp   = (clamp_a > COUNT_W'(RESULT_LIMIT)) ? REM_W'(RESULT_LIMIT)
                                                     : REM_W'(clamp_a);
    end

    always_comb
    begin
        sts.action      = action_reg;
        sts.id_ok       = id_ok;
        sts.item_queued = id_ok && queued_reg[id_slot];
        sts.cnt_zero    = (clamp == '0);
        sts.walk_last   = (rem_reg == REM_W'(1));
    end

    // ram ports
    always_comb
    begin
        nx_we    = 1'b0;
        nx_waddr = SLOT_W'(tail_reg);
        nx_wdata = id_link;
        pv_we    = 1'b0;
        pv_waddr = id_slot;
        pv_wdata = tail_reg;
        if (cmd.append)
        begin
            nx_we = (tail_reg != NIL_LINK);
            pv_we = 1'b1;
        end
        else if (cmd.unlink)
        begin
            nx_we    = (ul_p != NIL_LINK);
            nx_waddr = SLOT_W'(ul_p);
            nx_wdata = ul_n;
            pv_we    = (ul_n != NIL_LINK);
            pv_waddr = SLOT_W'(ul_n);
            pv_wdata = ul_p;
        end
        nx_re    = cmd.rd_item || cmd.rd_head || cmd.walk;
        nx_raddr = cmd.walk ? SLOT_W'(wk_n) : (cmd.rd_head ? SLOT_W'(head_reg) : id_slot);
        pv_re    = cmd.rd_item;
        pv_raddr = id_slot;
    end

    // list update and result
    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        occ_next    = occ_reg;
        queued_next = queued_reg;
        rem_next    = rem_reg;
        done_next   = 1'b0;
        valid_next  = 1'b0;
        wid_next    = '0;
        last_next   = 1'b1;
        status_next = 1'b0;
        if (cmd.append)
        begin
            if (head_reg == NIL_LINK)
            begin
                head_next = id_link;
            end
            tail_next            = id_link;
            queued_next[id_slot] = 1'b1;
            occ_next             = occ_reg + LINK_W'(1);
        end
        else if (cmd.unlink)
        begin
            if (head_reg == id_link)
            begin
                head_next = ul_n;
            end
            if (tail_reg == id_link)
            begin
                tail_next = ul_p;
            end
            queued_next[id_slot] = 1'b0;
            occ_next             = occ_reg - LINK_W'(1);
            done_next            = 1'b1;
            valid_next           = (action_reg == ACT_WAKE_ONE);
            wid_next             = (action_reg == ACT_WAKE_ONE) ? id_reg : '0;
        end
        else if (cmd.walk)
        begin
            head_next = wk_n;
            if (head_reg == tail_reg)
            begin
                tail_next = NIL_LINK;
            end
            queued_next[SLOT_W'(head_reg)] = 1'b0;
            occ_next   = occ_reg - LINK_W'(1);
            rem_next   = rem_reg - REM_W'(1);
            done_next  = 1'b1;
            valid_next = 1'b1;
            wid_next   = ID_W'(head_reg);
            last_next  = (rem_reg == REM_W'(1));
        end
        if (cmd.rd_head)
        begin
            rem_next = clamp;
        end
        if (cmd.emit_none)
        begin
            done_next   = 1'b1;
            status_next = cmd.dup;
        end
        if (cmd.emit_id)
        begin
            done_next  = 1'b1;
            valid_next = 1'b1;
            wid_next   = id_reg;
        end
        empty_next = (occ_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= NIL_LINK;
            tail_reg   <= NIL_LINK;
            occ_reg    <= '0;
            queued_reg <= '0;
            rem_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            occ_reg    <= occ_next;
            queued_reg <= queued_next;
            rem_reg    <= rem_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= action_t'(action);
            id_reg     <= waiter_id;
            count_reg  <= wake_count;
        end
        valid_reg  <= valid_next;
        wid_reg    <= wid_next;
        last_reg   <= last_next;
        empty_reg  <= empty_next;
        status_reg <= status_next;
    end

    assign done        = done_reg;
    assign woken_valid = valid_reg;
    assign woken_id    = wid_reg;
    assign last        = last_reg;
    assign queue_empty = empty_reg;
    assign status      = status_reg;

    `FWQ_ASSERT_IMP(a_empty_ends, occ_reg == '0, (head_reg == NIL_LINK) && (tail_reg == NIL_LINK), "empty queue keeps a head or tail")
    `FWQ_ASSERT_IMP(a_full_ends, occ_reg != '0, (head_reg != NIL_LINK) && (tail_reg != NIL_LINK), "nonempty queue lost its head or tail")
    `FWQ_ASSERT_IMP(a_flag_count, 1'b1, $countones(queued_reg) == int'(occ_reg), "queued flags disagree with occupancy")
    `FWQ_ASSERT_NXT(a_walk_emits, cmd.walk, done_reg && valid_reg, "walk step emitted no woken word")

endmodule

/* sv/fifo_wait_queue_with_removal_core.sv */
// top level of the fifo wait queue with removal
// depends on fwq_pkg, fwq_ctrl, fwq_dp (which holds the fwq_ram link stores)
//
// usage
//   a command word (action, waiter_id, wake_count) is taken at a rising edge
//   with start high and busy low; busy stays high until the queue is ready
//   for the next command
//   actions: wait appends at the tail, unwait removes from anywhere, wake
//   many pops up to wake_count waiters from the head, wake specific removes
//   the named waiter if queued and always reports it
//   each result word sits on the result ports for one cycle with done high;
//   the receiver cannot stall, so no back pressure exists on that side
// timing
//   wait, unwait of an idle slot, wake specific of an idle slot and an empty
//   wake many: result from execute, next command may be taken while shown
//   unwait or wake specific of a queued slot: adds the unlink state
//   wake many of n waiters: execute reads the head's next link, then one word
//   per cycle from the walk state; the walk is set by the registered
//   read port of the next-link ram, prefetched one waiter ahead
//   the command after a burst may be taken while the last word is shown
// reset
//   rst_n clears the head, tail, occupancy and queued flags; link rams need
//   no clearing since only links of queued slots are ever used
module fifo_wait_queue_with_removal_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  action,
    input  logic [fwq_pkg::ID_W-1:0]    waiter_id,
    input  logic [fwq_pkg::COUNT_W-1:0] wake_count,
    output logic                        done,
    output logic                        woken_valid,
    output logic [fwq_pkg::ID_W-1:0]    woken_id,
    output logic                        last,
    output logic                        queue_empty,
    output logic                        status
);
    import fwq_pkg::*;

    // command and status between sequencer and datapath
    cmd_t cmd;
    sts_t sts;

    fwq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    fwq_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .action      (action),
        .waiter_id   (waiter_id),
        .wake_count  (wake_count),
        .cmd         (cmd),
        .sts         (sts),
        .done        (done),
        .woken_valid (woken_valid),
        .woken_id    (woken_id),
        .last        (last),
        .queue_empty (queue_empty),
        .status      (status)
    );

endmodule
